// File: rtl/sda_pkg.sv
package sda_pkg;

	localparam int ADDR_W  = 32;
	localparam int DESC_W  = 64;
	localparam int IDX_W   = 8;
	localparam int ESZ_W   = 2;
	localparam int CFG_W   = 9;
	localparam int OFS_W   = 18;
	localparam int SMALL_W = 11;
	localparam int PROD_W  = 26;
	localparam int OFF_W   = 28;
	localparam int YM_W    = 3;

	// The k index is divided in stages, a fixed number of quotient bits each.
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = IDX_W / DIV_BITS;

	localparam int DESC_BASE_LSB   = 0;
	localparam int DESC_LEAD_LSB   = 16;
	localparam int DESC_STRIDE_LSB = 32;
	localparam int DESC_SWZ_LSB    = 62;
	localparam int FLD_W           = 14;

	localparam logic [1:0] SWZ_NONE = 2'd0;
	localparam logic [1:0] SWZ_128  = 2'd1;
	localparam logic [1:0] SWZ_64   = 2'd2;
	localparam logic [1:0] SWZ_32   = 2'd3;

	localparam logic MODE_KMAJ  = 1'b0;
	localparam logic MODE_MNMAJ = 1'b1;

	localparam logic [ESZ_W-1:0] ESZ_LG_MAX = 2'd2;
	localparam logic [CFG_W-1:0] CFG_RESET  = 9'd8;

	// One item on its way through the decode and divide stages.
	typedef struct packed {
		logic               use_div;
		logic [ESZ_W-1:0]   lg;
		logic [IDX_W-1:0]   x;
		logic [OFS_W-1:0]   p;
		logic [IDX_W-1:0]   y;
		logic [OFS_W-1:0]   q;
		logic [SMALL_W-1:0] r;
		logic [IDX_W-1:0]   rem;
		logic [OFS_W-1:0]   ck;
		logic [OFS_W-1:0]   boff;
		logic [OFS_W-1:0]   pbase;
		logic [YM_W-1:0]    ymsk;
	} op_t;

	typedef struct packed {
		logic [PROD_W-1:0]  pa;
		logic [PROD_W-1:0]  pb;
		logic [SMALL_W-1:0] r;
		logic [OFS_W-1:0]   boff;
		logic [OFS_W-1:0]   pbase;
		logic [YM_W-1:0]    ymsk;
	} prod_t;

	typedef struct packed {
		logic [OFF_W-1:0] val;
		logic [OFS_W-1:0] boff;
		logic [OFS_W-1:0] pbase;
		logic [YM_W-1:0]  ymsk;
	} sum_t;

endpackage

// File: rtl/sda_decode.sv
module sda_decode (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      mode,
	input  logic [sda_pkg::DESC_W-1:0] descriptor,
	input  logic [sda_pkg::IDX_W-1:0] mn_index,
	input  logic [sda_pkg::IDX_W-1:0] k_index,
	input  logic [sda_pkg::ESZ_W-1:0] elem_size_log2,
	input  logic [sda_pkg::CFG_W-1:0] dk,
	output logic                      s1_valid,
	output sda_pkg::op_t              s1_op
);

	sda_pkg::op_t op;

	always_comb begin
		logic [sda_pkg::ESZ_W-1:0] lg;
		logic [sda_pkg::OFS_W-1:0] base, lead, stride, lead_k, pmask;
		logic [1:0] sm;
		logic [2:0] swz_lg, epc_lg, rps_lg;
		logic [sda_pkg::CFG_W-1:0] dk_eff;
		logic [sda_pkg::IDX_W-1:0] epc_m, rps_m;
		lg = (elem_size_log2 > sda_pkg::ESZ_LG_MAX) ? sda_pkg::ESZ_LG_MAX : elem_size_log2;
		base   = {descriptor[sda_pkg::DESC_BASE_LSB +: sda_pkg::FLD_W], 4'b0};
		lead   = {descriptor[sda_pkg::DESC_LEAD_LSB +: sda_pkg::FLD_W], 4'b0};
		stride = {descriptor[sda_pkg::DESC_STRIDE_LSB +: sda_pkg::FLD_W], 4'b0};
		sm     = descriptor[sda_pkg::DESC_SWZ_LSB +: 2];
		op = '0;
		case (sm)
			sda_pkg::SWZ_128: begin
				swz_lg = 3'd7; op.ymsk = 3'b111; pmask = 18'h003FF;
			end
			sda_pkg::SWZ_64: begin
				swz_lg = 3'd6; op.ymsk = 3'b011; pmask = 18'h001FF;
			end
			sda_pkg::SWZ_32: begin
				swz_lg = 3'd5; op.ymsk = 3'b001; pmask = 18'h000FF;
			end
			default: begin
				swz_lg = 3'd0; op.ymsk = 3'b000; pmask = '1;
			end
		endcase
		op.boff  = base & pmask;
		op.pbase = base & ~pmask;
		op.lg    = lg;
		epc_lg = 3'd4 - {1'b0, lg};
		rps_lg = swz_lg - {1'b0, lg};
		epc_m  = sda_pkg::IDX_W'((9'd1 << epc_lg) - 9'd1);
		rps_m  = sda_pkg::IDX_W'((9'd1 << rps_lg) - 9'd1);
		dk_eff = (dk == '0) ? sda_pkg::CFG_W'(1) : dk;
		lead_k = (lead == '0) ? sda_pkg::OFS_W'(16) : lead;
		op.ck  = (stride == '0) ? sda_pkg::OFS_W'(dk_eff) : (stride >> lg);
		if (mode == sda_pkg::MODE_KMAJ) begin
			if (sm != sda_pkg::SWZ_NONE) begin
				op.x = mn_index >> 3;
				op.p = stride;
				op.y = k_index >> epc_lg;
				op.q = lead_k;
				op.r = (sda_pkg::SMALL_W'(mn_index & 8'd7) << swz_lg)
					+ (sda_pkg::SMALL_W'(k_index & epc_m) << lg);
			end else begin
				op.use_div = 1'b1;
				op.x = k_index;
				op.p = lead;
				op.y = mn_index;
				op.q = stride;
			end
		end else begin
			if (sm == sda_pkg::SWZ_NONE) begin
				op.x = mn_index >> epc_lg;
				op.p = stride;
				op.y = k_index >> 3;
				op.q = lead;
				op.r = (sda_pkg::SMALL_W'(mn_index & epc_m) << lg)
					+ (sda_pkg::SMALL_W'(k_index & 8'd7) << 4);
			end else begin
				op.x = mn_index >> rps_lg;
				op.p = lead;
				op.y = k_index >> 3;
				op.q = stride;
				op.r = (sda_pkg::SMALL_W'(mn_index & rps_m) << lg)
					+ (sda_pkg::SMALL_W'(k_index & 8'd7) << swz_lg);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		s1_op <= op;
	end

endmodule

// File: rtl/sda_div_step.sv
module sda_div_step (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  sda_pkg::op_t in_op,
	output logic         out_valid,
	output sda_pkg::op_t out_op
);

	sda_pkg::op_t op;

	// Two restoring division steps: the quotient bits shift into x as the
	// dividend bits shift out of it.
	always_comb begin
		logic [sda_pkg::IDX_W:0] r9;
		op = in_op;
		r9 = '0;
		for (int i = 0; i < sda_pkg::DIV_BITS; i++) begin
			if (op.use_div) begin
				r9 = {op.rem, op.x[sda_pkg::IDX_W-1]};
				op.x = op.x << 1;
				if (sda_pkg::OFS_W'(r9) >= op.ck) begin
					op.rem  = sda_pkg::IDX_W'(r9 - op.ck[sda_pkg::IDX_W:0]);
					op.x[0] = 1'b1;
				end else begin
					op.rem = r9[sda_pkg::IDX_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_op <= op;
	end

endmodule

// File: rtl/sda_mac.sv
module sda_mac (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  sda_pkg::op_t in_op,
	output logic         s7_valid,
	output sda_pkg::sum_t s7_sum
);

	logic           s6_valid;
	sda_pkg::prod_t s6_prod;
	sda_pkg::prod_t prod;

	always_comb begin
		prod.pa    = sda_pkg::PROD_W'(in_op.x) * sda_pkg::PROD_W'(in_op.p);
		prod.pb    = sda_pkg::PROD_W'(in_op.y) * sda_pkg::PROD_W'(in_op.q);
		prod.r     = in_op.use_div ? (sda_pkg::SMALL_W'(in_op.rem) << in_op.lg) : in_op.r;
		prod.boff  = in_op.boff;
		prod.pbase = in_op.pbase;
		prod.ymsk  = in_op.ymsk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s6_valid <= 1'b0;
			s7_valid <= 1'b0;
		end else begin
			s6_valid <= in_valid;
			s7_valid <= s6_valid;
		end
	end

	always_ff @(posedge clk) begin
		s6_prod      <= prod;
		s7_sum.val   <= sda_pkg::OFF_W'(s6_prod.pa) + sda_pkg::OFF_W'(s6_prod.pb)
			+ sda_pkg::OFF_W'(s6_prod.r);
		s7_sum.boff  <= s6_prod.boff;
		s7_sum.pbase <= s6_prod.pbase;
		s7_sum.ymsk  <= s6_prod.ymsk;
	end

endmodule

// File: rtl/swizzled_smem_descriptor_address.sv
// Channel   Handshake              Payload
// command   start / busy           mode, descriptor, mn_index, k_index, elem_size_log2
// result    done (strobe)          smem_address
// config    cfg_valid / cfg_ready  cfg_data (default contiguous k)
//
// One transfer is taken every cycle; busy is never raised.
// Each command passes in order through decode, four divide stages
// (two quotient bits each), multiply, sum, period offset add and the swizzle add.
// arst_n clears all valid bits and loads the default contiguous k with eight.
// The receiver cannot stall, so the pipeline never stops.
module swizzled_smem_descriptor_address (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       mode,
	input  logic [sda_pkg::DESC_W-1:0] descriptor,
	input  logic [sda_pkg::IDX_W-1:0]  mn_index,
	input  logic [sda_pkg::IDX_W-1:0]  k_index,
	input  logic [sda_pkg::ESZ_W-1:0]  elem_size_log2,
	output logic                       done,
	output logic [sda_pkg::ADDR_W-1:0] smem_address,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sda_pkg::CFG_W-1:0]  cfg_data
);

	logic [sda_pkg::CFG_W-1:0] dk_q;
	logic                      dv [0:sda_pkg::DIV_STAGES];
	sda_pkg::op_t              dop [0:sda_pkg::DIV_STAGES];
	logic                      valid_s7;
	sda_pkg::sum_t             sum_s7;
	logic                      valid_s8;
	logic [sda_pkg::OFF_W-1:0] poff_s8;
	logic [sda_pkg::OFS_W-1:0] pbase_s8;
	logic [sda_pkg::YM_W-1:0]  ymsk_s8;
	logic [sda_pkg::OFF_W-1:0] swz;

	// The pipeline has no back pressure, so both inputs are always open.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dk_q <= sda_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dk_q <= cfg_data;
		end
	end

	// Stage one decodes the descriptor and reduces every layout to
	// x*p + y*q + r. The unswizzled K-major path still needs k / ck and
	// k % ck, which the divide stages produce in x and rem.
	sda_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (start && !busy),
		.mode           (mode),
		.descriptor     (descriptor),
		.mn_index       (mn_index),
		.k_index        (k_index),
		.elem_size_log2 (elem_size_log2),
		.dk             (dk_q),
		.s1_valid       (dv[0]),
		.s1_op          (dop[0])
	);

	for (genvar g = 0; g < sda_pkg::DIV_STAGES; g++) begin : g_div
		sda_div_step u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv[g]),
			.in_op     (dop[g]),
			.out_valid (dv[g+1]),
			.out_op    (dop[g+1])
		);
	end

	sda_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dv[sda_pkg::DIV_STAGES]),
		.in_op    (dop[sda_pkg::DIV_STAGES]),
		.s7_valid (valid_s7),
		.s7_sum   (sum_s7)
	);

	// The swizzle period is aligned to the base: the base bits inside the
	// period are added to the offset, and the aligned part comes back last.
	// Without swizzle the whole base sits in boff and pbase is zero.
	always_comb begin
		swz = poff_s8;
		swz[6:4] = poff_s8[6:4] ^ (poff_s8[9:7] & ymsk_s8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s8 <= valid_s7;
			done     <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		poff_s8      <= sum_s7.val + sda_pkg::OFF_W'(sum_s7.boff);
		pbase_s8     <= sum_s7.pbase;
		ymsk_s8      <= sum_s7.ymsk;
		smem_address <= sda_pkg::ADDR_W'(swz + sda_pkg::OFF_W'(pbase_s8));
	end

	a_start_done : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##9 done)
		else $error("accepted command gave no result");

	a_idle_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##9 !done)
		else $error("result without command");

	a_cfg_write : assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (dk_q == $past(cfg_data)))
		else $error("config write lost");

endmodule

// File: sim/swizzled_smem_descriptor_address_tb.sv
module swizzled_smem_descriptor_address_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The clock runs at 50 MHz, and reset is held low before the first test starts.
	localparam int CLK_HALF  = 10;
	localparam int LATENCY   = 9;
	localparam int WDOG_MAX  = 2000;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          mode;
	logic [sda_pkg::DESC_W-1:0]    descriptor;
	logic [sda_pkg::IDX_W-1:0]     mn_index;
	logic [sda_pkg::IDX_W-1:0]     k_index;
	logic [sda_pkg::ESZ_W-1:0]     elem_size_log2;
	logic                          done;
	logic [sda_pkg::ADDR_W-1:0]    smem_address;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [sda_pkg::CFG_W-1:0]     cfg_data;

	// The testbench keeps its own copy of the contiguous-k register. The
	// queue below holds each predicted address in the order of the transfers.
	logic [sda_pkg::CFG_W-1:0]     contig_k_shadow;
	logic [sda_pkg::ADDR_W-1:0]    pending_addr_q[$];
	int                            fail_count;
	int                            items_sent;
	int                            results_seen;
	int                            idle_cycles;
	bit                            steady_phase;

	swizzled_smem_descriptor_address i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.descriptor(descriptor), .mn_index(mn_index), .k_index(k_index),
		.elem_size_log2(elem_size_log2), .done(done), .smem_address(smem_address),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Width of one swizzle row in bytes. A mode of zero means no swizzle.
	function automatic longint unsigned swz_row_bytes(logic [1:0] sm);
		case (sm)
			sda_pkg::SWZ_128: return 128;
			sda_pkg::SWZ_64:  return 64;
			sda_pkg::SWZ_32:  return 32;
			default: return 0;
		endcase
	endfunction

	// The XOR swizzle works inside a period of eight rows that is aligned to
	// the base. Because of that, a base that starts partway into a period
	// keeps its low bits when the row bits are selected.
	function automatic longint unsigned place_swizzled(longint unsigned base,
			longint unsigned off, logic [1:0] sm);
		longint unsigned width, period, pbase, poff, ymask;
		int unsigned ybits;
		width = swz_row_bytes(sm);
		if (width == 0)
			return base + off;
		ybits = (sm == sda_pkg::SWZ_128) ? 3 : (sm == sda_pkg::SWZ_64) ? 2 : 1;
		period = width * 8;
		pbase = base & ~(period - 1);
		poff = (base - pbase) + off;
		ymask = ((64'd1 << ybits) - 1) << 7;
		return pbase + (poff ^ ((poff & ymask) >> 3));
	endfunction

	function automatic logic [sda_pkg::ADDR_W-1:0] predict_smem_address(logic md,
			logic [sda_pkg::DESC_W-1:0] desc, logic [sda_pkg::IDX_W-1:0] mn,
			logic [sda_pkg::IDX_W-1:0] k, logic [sda_pkg::ESZ_W-1:0] lg_in);
		longint unsigned esz, epc, base, lead, stride, swz, off, addr;
		longint unsigned lead_eff, dk, ck, rps;
		logic [1:0] sm;
		logic [sda_pkg::ESZ_W-1:0] lg;
		// An element size code of three is treated as four-byte elements.
		lg = (lg_in > sda_pkg::ESZ_LG_MAX) ? sda_pkg::ESZ_LG_MAX : lg_in;
		esz = 64'd1 << lg;
		epc = 16 / esz;
		base = longint'(desc[sda_pkg::DESC_BASE_LSB +: sda_pkg::FLD_W]) << 4;
		lead = longint'(desc[sda_pkg::DESC_LEAD_LSB +: sda_pkg::FLD_W]) << 4;
		stride = longint'(desc[sda_pkg::DESC_STRIDE_LSB +: sda_pkg::FLD_W]) << 4;
		sm = desc[sda_pkg::DESC_SWZ_LSB +: 2];
		swz = swz_row_bytes(sm);
		if (md == sda_pkg::MODE_KMAJ) begin
			if (swz != 0) begin
				// With a swizzle, a leading offset of zero means 16 bytes.
				lead_eff = (lead == 0) ? 16 : lead;
				off = (mn / 8) * stride + (mn % 8) * swz + (k / epc) * lead_eff
					+ (k % epc) * esz;
				addr = place_swizzled(base, off, sm);
			end else begin
				// A register value of zero counts as one.
				dk = (contig_k_shadow == 0) ? 1 : contig_k_shadow;
				ck = (stride == 0) ? dk : (stride / esz);
				if (ck == 0)
					ck = dk;
				addr = base + (k / ck) * lead + mn * stride + (k % ck) * esz;
			end
		end else begin
			if (swz == 0) begin
				addr = base + (mn / epc) * stride + (mn % epc) * esz + (k / 8) * lead
					+ (k % 8) * 16;
			end else begin
				rps = swz / esz;
				off = (mn / rps) * lead + (mn % rps) * esz + (k / 8) * stride
					+ (k % 8) * swz;
				addr = place_swizzled(base, off, sm);
			end
		end
		return addr[sda_pkg::ADDR_W-1:0];
	endfunction

	// The command handshake waits on a random gap with a chance of about 28 in 100,
	// except during the phase with no gaps at all.
	function automatic bit take_gap();
		return !steady_phase && ($urandom_range(99) < 28);
	endfunction

	// Sends one command and waits for the transfer to finish. The command
	// stays valid after the transfer, so a following call can send at once;
	// start is lowered by a gap, a register write or the end of the run.
	task automatic send_address_request(logic md, logic [sda_pkg::DESC_W-1:0] desc,
			logic [sda_pkg::IDX_W-1:0] mn, logic [sda_pkg::IDX_W-1:0] k,
			logic [sda_pkg::ESZ_W-1:0] lg);
		while (take_gap()) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode <= md;
		descriptor <= desc;
		mn_index <= mn;
		k_index <= k;
		elem_size_log2 <= lg;
		do
			@(posedge clk);
		while (busy);
		pending_addr_q = {pending_addr_q, predict_smem_address(md, desc, mn, k, lg)};
		items_sent++;
	endtask

	// Builds a descriptor from its fields, with random bits in the spare
	// positions.
	function automatic logic [sda_pkg::DESC_W-1:0] make_desc(
			logic [sda_pkg::FLD_W-1:0] b, logic [sda_pkg::FLD_W-1:0] l,
			logic [sda_pkg::FLD_W-1:0] s, logic [1:0] sm);
		logic [sda_pkg::DESC_W-1:0] d;
		d = {$urandom, $urandom};
		d[sda_pkg::DESC_BASE_LSB +: sda_pkg::FLD_W] = b;
		d[sda_pkg::DESC_LEAD_LSB +: sda_pkg::FLD_W] = l;
		d[sda_pkg::DESC_STRIDE_LSB +: sda_pkg::FLD_W] = s;
		d[sda_pkg::DESC_SWZ_LSB +: 2] = sm;
		return d;
	endfunction

	// The register is written only when the pipeline is empty. This waits
	// for all results, plus the pipeline depth for safety.
	task automatic write_contig_k(logic [sda_pkg::CFG_W-1:0] val);
		start <= 1'b0;
		wait (pending_addr_q.size() == 0);
		repeat (LATENCY + 2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		contig_k_shadow = val;
	endtask

	// Directed cases. They cover the field extremes, both layouts, every
	// swizzle mode, every element size code including three, a zero
	// leading offset, a zero stride, a base that starts inside a period,
	// and large offsets.
	task automatic test_directed_corners();
		logic [1:0] sm;
		for (int i = 0; i < 4; i++) begin
			sm = i[1:0];
			send_address_request(sda_pkg::MODE_KMAJ, make_desc('0, '0, '0, sm),
				8'hFF, 8'hFF, 2'd3);
			send_address_request(sda_pkg::MODE_MNMAJ, make_desc('1, '1, '1, sm),
				8'hFF, 8'hFF, 2'd2);
			send_address_request(sda_pkg::MODE_KMAJ,
				make_desc(14'h35, 14'd0, 14'd1, sm), 8'd9, 8'd37, 2'd1);
			send_address_request(sda_pkg::MODE_MNMAJ,
				make_desc(14'h1F, 14'd3, 14'd0, sm), 8'd77, 8'd13, 2'd0);
			send_address_request(sda_pkg::MODE_KMAJ, make_desc('1, '1, '1, sm),
				8'd0, 8'd0, 2'd0);
		end
		send_address_request(sda_pkg::MODE_KMAJ, {64{1'b1}}, 8'hFF, 8'hFF, 2'd3);
		send_address_request(sda_pkg::MODE_MNMAJ, 64'd0, 8'd0, 8'd0, 2'd0);
	endtask

	// Random commands. All descriptor bits are random, with small strides and zero
	// leading offsets weighted so that the interesting paths are reached.
	task automatic test_random_addresses(int count);
		logic [sda_pkg::DESC_W-1:0] d;
		for (int i = 0; i < count; i++) begin
			d = {$urandom, $urandom};
			if ($urandom_range(3) == 0)
				d[sda_pkg::DESC_STRIDE_LSB +: sda_pkg::FLD_W] =
					sda_pkg::FLD_W'($urandom_range(3));
			if ($urandom_range(4) == 0)
				d[sda_pkg::DESC_LEAD_LSB +: sda_pkg::FLD_W] = '0;
			send_address_request(1'($urandom_range(1)), d,
				sda_pkg::IDX_W'($urandom), sda_pkg::IDX_W'($urandom),
				sda_pkg::ESZ_W'($urandom_range(3)));
		end
	endtask

	// Writes the register, then runs unswizzled K-major commands, the only path that reads it.
	task automatic test_contig_k_setting(logic [sda_pkg::CFG_W-1:0] val, int count);
		write_contig_k(val);
		for (int i = 0; i < count; i++)
			send_address_request(sda_pkg::MODE_KMAJ,
				make_desc(sda_pkg::FLD_W'($urandom), sda_pkg::FLD_W'($urandom),
					sda_pkg::FLD_W'($urandom_range(2)), sda_pkg::SWZ_NONE),
				sda_pkg::IDX_W'($urandom), sda_pkg::IDX_W'($urandom),
				sda_pkg::ESZ_W'($urandom_range(3)));
	endtask

	// Checks each result strobe against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (pending_addr_q.size() == 0) begin
				$error("smem_address: unexpected result %h", smem_address);
				fail_count++;
			end else begin
				if (smem_address !== pending_addr_q[0]) begin
					$error("smem_address: expected %h actual %h", pending_addr_q[0],
						smem_address);
					fail_count++;
				end
				void'(pending_addr_q.pop_front());
			end
		end
	end

	// Watchdog. It counts the cycles in which no transfer of any kind
	// happens.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("watchdog expired with %0d results outstanding",
				pending_addr_q.size());
			$display("swizzled_smem_descriptor_address_tb failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = 1'b0;
		descriptor = '0;
		mn_index = '0;
		k_index = '0;
		elem_size_log2 = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		contig_k_shadow = sda_pkg::CFG_RESET;
		fail_count = 0;
		items_sent = 0;
		results_seen = 0;
		idle_cycles = 0;
		steady_phase = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_random_addresses(250);
		test_contig_k_setting(9'd1, 40);
		test_contig_k_setting(9'd0, 40);
		test_contig_k_setting(9'd511, 40);
		test_contig_k_setting(9'd256, 40);
		steady_phase = 1'b1;
		test_contig_k_setting(sda_pkg::CFG_W'($urandom_range(2, 255)), 30);
		test_random_addresses(120);
		steady_phase = 1'b0;
		test_random_addresses(60);

		start <= 1'b0;
		wait (pending_addr_q.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
		$display("Sent %0d address commands and checked %0d results.", items_sent,
			results_seen);
		$display("The run covered both layouts, all swizzle modes and six contiguous-k settings.");
		if (fail_count == 0 && pending_addr_q.size() == 0)
			$display("swizzled_smem_descriptor_address_tb passed");
		else
			$display("swizzled_smem_descriptor_address_tb failed");
		$finish;
	end

endmodule
